// ----- sv/las_pkg.sv -----
// ----------------------------------------------------------------------------
// las_pkg: shared types and constants for the local alignment score fill
// Command codes, register indexes, sequencer states and the control and
// status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package las_pkg;

  // input command codes
  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_START       = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MATCH      = 2'd0;
  localparam logic [1:0] REG_MISMATCH   = 2'd1;
  localparam logic [1:0] REG_GAP_OPEN   = 2'd2;
  localparam logic [1:0] REG_GAP_EXTEND = 2'd3;

  // configuration reset values
  localparam logic [7:0] RST_MATCH      = 8'd2;
  localparam logic [7:0] RST_MISMATCH   = 8'd1;
  localparam logic [7:0] RST_GAP_OPEN   = 8'd2;
  localparam logic [7:0] RST_GAP_EXTEND = 8'd1;

  localparam int unsigned POS_WIDTH  = 11;
  localparam int unsigned BEST_WIDTH = 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic row_issue;
    logic cell_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic col_last;
    logic row_last;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/las_ram.sv -----
// ----------------------------------------------------------------------------
// las_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module las_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/las_ctrl.sv -----
// ----------------------------------------------------------------------------
// las_ctrl: sequencer for the score fill
// Takes load and start beats while idle, then walks rows and cells and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module las_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_cmd,
  input  las_pkg::stat_t  stat,
  output las_pkg::ctrl_t  ctrl
);

  las_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= las_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      las_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          priority if (in_cmd == las_pkg::CMD_LOAD_FIRST) begin
            ctrl.load_first = 1'b1;
          end else if (in_cmd == las_pkg::CMD_LOAD_SECOND) begin
            ctrl.load_second = 1'b1;
          end else if (in_cmd == las_pkg::CMD_START) begin
            ctrl.start = 1'b1;
            state_nxt  = stat.empty ? las_pkg::ST_DONE : las_pkg::ST_ROW;
          end else begin
            // unused command: beat is dropped
          end
        end
      end
      las_pkg::ST_ROW: begin
        ctrl.row_issue = 1'b1;
        state_nxt      = las_pkg::ST_CELL;
      end
      las_pkg::ST_CELL: begin
        ctrl.cell_step = 1'b1;
        if (stat.col_last) begin
          state_nxt = stat.row_last ? las_pkg::ST_DONE : las_pkg::ST_ROW;
        end
      end
      las_pkg::ST_DONE: begin
        if (stat.out_free) begin
          ctrl.finish = 1'b1;
          state_nxt   = las_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = las_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/las_dp.sv -----
// ----------------------------------------------------------------------------
// las_dp: datapath for the score fill
// Sequence stores, row buffer, cell scoring, best tracking, config
// registers and the output register.
// ----------------------------------------------------------------------------
module las_dp #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned SCORE_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  las_pkg::ctrl_t                  ctrl,
  output las_pkg::stat_t                  stat,
  input  logic [7:0]                      in_symbol,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [7:0]                      cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [las_pkg::BEST_WIDTH-1:0]  out_best_score,
  output logic [las_pkg::POS_WIDTH-1:0]   out_end_row,
  output logic [las_pkg::POS_WIDTH-1:0]   out_end_column,
  output logic                            out_swapped,
  output logic                            out_overflow
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned W  = SCORE_WIDTH;
  localparam int unsigned XW = W + 2;
  localparam int unsigned BX = 34;
  localparam int unsigned PW = las_pkg::POS_WIDTH;

  localparam logic signed [XW-1:0] SMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN = {3'b111, {(W-1){1'b0}}};
  localparam logic signed [BX-1:0] BEST_CAP = 34'sd32767;
  localparam logic [LW-1:0]        LEN_FULL = LW'(MAX_LEN);
  localparam logic [LW-1:0]        ONE      = LW'(1);

  function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SMAX) begin
      r = SMAX[W-1:0];
    end else if (v < SMIN) begin
      r = SMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [7:0] match_r, mismatch_r, gap_open_r, gap_ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= las_pkg::RST_MATCH;
      mismatch_r <= las_pkg::RST_MISMATCH;
      gap_open_r <= las_pkg::RST_GAP_OPEN;
      gap_ext_r  <= las_pkg::RST_GAP_EXTEND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        las_pkg::REG_MATCH:      match_r    <= cfg_data;
        las_pkg::REG_MISMATCH:   mismatch_r <= cfg_data;
        las_pkg::REG_GAP_OPEN:   gap_open_r <= cfg_data;
        las_pkg::REG_GAP_EXTEND: gap_ext_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // lengths and job geometry
  logic [LW-1:0] first_len_r, second_len_r;
  logic          overflow_r;
  logic          swp_r;
  logic [LW-1:0] ncols_r, nrows_r;
  logic [LW-1:0] i_r, j_r;
  logic [LW-1:0] i_m1, j_m1;
  logic          first_full, second_full;

  assign first_full  = (first_len_r == LEN_FULL);
  assign second_full = (second_len_r == LEN_FULL);
  assign i_m1        = i_r - ONE;
  assign j_m1        = j_r - ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_len_r  <= '0;
      second_len_r <= '0;
      overflow_r   <= 1'b0;
    end else if (ctrl.finish) begin
      first_len_r  <= '0;
      second_len_r <= '0;
      overflow_r   <= 1'b0;
    end else if (ctrl.load_first) begin
      if (first_full) begin
        overflow_r <= 1'b1;
      end else begin
        first_len_r <= first_len_r + ONE;
      end
    end else if (ctrl.load_second) begin
      if (second_full) begin
        overflow_r <= 1'b1;
      end else begin
        second_len_r <= second_len_r + ONE;
      end
    end
  end

  // sequence stores and row buffer
  logic          col_re, row_re;
  logic [AW-1:0] col_addr, row_addr;
  logic          first_re, second_re;
  logic [AW-1:0] first_raddr, second_raddr;
  logic [7:0]    first_rdata, second_rdata;
  logic [7:0]    col_sym, row_sym;
  logic [W-1:0]  rb_rdata;
  logic [W-1:0]  stored;

  assign col_re       = ctrl.row_issue | (ctrl.cell_step & ~stat.col_last);
  assign row_re       = ctrl.row_issue;
  assign col_addr     = ctrl.row_issue ? '0 : j_r[AW-1:0];
  assign row_addr     = i_m1[AW-1:0];
  assign first_re     = swp_r ? row_re : col_re;
  assign second_re    = swp_r ? col_re : row_re;
  assign first_raddr  = swp_r ? row_addr : col_addr;
  assign second_raddr = swp_r ? col_addr : row_addr;
  assign col_sym      = swp_r ? second_rdata : first_rdata;
  assign row_sym      = swp_r ? first_rdata : second_rdata;

  las_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
    .clk   (clk),
    .we    (ctrl.load_first & ~first_full),
    .waddr (first_len_r[AW-1:0]),
    .wdata (in_symbol),
    .re    (first_re),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  las_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
    .clk   (clk),
    .we    (ctrl.load_second & ~second_full),
    .waddr (second_len_r[AW-1:0]),
    .wdata (in_symbol),
    .re    (second_re),
    .raddr (second_raddr),
    .rdata (second_rdata)
  );

  // previous-row scores; row 1 ignores the read data, so no clearing is needed
  las_ram #(.WIDTH(W), .DEPTH(MAX_LEN)) u_row_ram (
    .clk   (clk),
    .we    (ctrl.cell_step),
    .waddr (j_m1[AW-1:0]),
    .wdata (stored),
    .re    (col_re),
    .raddr (col_addr),
    .rdata (rb_rdata)
  );

  // cell scoring
  logic signed [W-1:0]  left_r, diag_r, best_r;
  logic                 gap_r;
  logic [LW-1:0]        best_i_r, best_j_r;
  logic signed [W-1:0]  up;
  logic signed [XW-1:0] diag_x, up_x, left_x, pen_x, ms_x, mm_x;
  logic signed [W-1:0]  a_s, b_s, c_s, s;
  logic                 gap_nxt;

  assign up     = (i_r == ONE) ? '0 : $signed(rb_rdata);
  assign diag_x = {{2{diag_r[W-1]}}, diag_r};
  assign up_x   = {{2{up[W-1]}}, up};
  assign left_x = {{2{left_r[W-1]}}, left_r};
  assign pen_x  = {{(XW-8){1'b0}}, (gap_r ? gap_ext_r : gap_open_r)};
  assign ms_x   = {{(XW-8){1'b0}}, match_r};
  assign mm_x   = {{(XW-8){1'b0}}, mismatch_r};

  always_comb begin
    a_s = (col_sym == row_sym) ? sat(diag_x + ms_x) : sat(diag_x - mm_x);
    b_s = sat(up_x - pen_x);
    c_s = sat(left_x - pen_x);
    // diagonal wins ties, then up
    if (a_s >= b_s && a_s >= c_s) begin
      s       = a_s;
      gap_nxt = 1'b0;
    end else begin
      s       = (b_s >= c_s) ? b_s : c_s;
      gap_nxt = 1'b1;
    end
    stored = s[W-1] ? '0 : s;
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      swp_r    <= (second_len_r > first_len_r);
      ncols_r  <= (second_len_r > first_len_r) ? second_len_r : first_len_r;
      nrows_r  <= (second_len_r > first_len_r) ? first_len_r : second_len_r;
      i_r      <= ONE;
      best_r   <= '0;
      best_i_r <= '0;
      best_j_r <= '0;
      gap_r    <= 1'b0;
    end
    if (ctrl.row_issue) begin
      j_r    <= ONE;
      left_r <= '0;
      diag_r <= '0;
    end
    if (ctrl.cell_step) begin
      gap_r  <= gap_nxt;
      left_r <= stored;
      diag_r <= up;
      if (s >= best_r) begin
        best_r   <= s;
        best_i_r <= i_r;
        best_j_r <= j_r;
      end
      if (!stat.col_last) begin
        j_r <= j_r + ONE;
      end else if (!stat.row_last) begin
        i_r <= i_r + ONE;
      end
    end
  end

  // result register
  logic                   out_valid_r;
  logic [BX-1:0]          best_bx;
  logic [LW+PW-1:0]       bi_ext, bj_ext;
  logic [las_pkg::BEST_WIDTH-1:0] best_score_r;
  logic [PW-1:0]          end_row_r, end_col_r;
  logic                   swapped_r, ovf_out_r;

  assign best_bx = {{(BX-W){best_r[W-1]}}, best_r};
  assign bi_ext  = {{PW{1'b0}}, best_i_r};
  assign bj_ext  = {{PW{1'b0}}, best_j_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      best_score_r <= ($signed(best_bx) > BEST_CAP) ? {las_pkg::BEST_WIDTH{1'b1}}
                                                     : best_bx[las_pkg::BEST_WIDTH-1:0];
      end_row_r    <= bi_ext[PW-1:0];
      end_col_r    <= bj_ext[PW-1:0];
      swapped_r    <= swp_r;
      ovf_out_r    <= overflow_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_score = best_score_r;
  assign out_end_row    = end_row_r;
  assign out_end_column = end_col_r;
  assign out_swapped    = swapped_r;
  assign out_overflow   = ovf_out_r;

  assign stat.empty    = (first_len_r == '0) || (second_len_r == '0);
  assign stat.col_last = (j_r == ncols_r);
  assign stat.row_last = (i_r == nrows_r);
  assign stat.out_free = ~out_valid_r | ~out_stall;

endmodule

// ----- sv/local_alignment_score_fill.sv -----
// ----------------------------------------------------------------------------
// local_alignment_score_fill: local alignment score fill engine
// Load symbols of two sequences, then start; one result beat per start.
// ----------------------------------------------------------------------------
// Load beats are taken one per cycle while the block is idle. A start beat
// holds the input stalled while the matrix is filled: a row state opens each
// row and a cell state scores each cell, until the result sits in the output
// register (an empty sequence goes straight to it), and further while an
// earlier result still waits stalled in that register. The cell loop feeds
// the left score and gap flag of each cell into the next cell. The result
// register frees the scorer, so loads for the next job may proceed while a
// result waits to be taken. The shorter sequence gives the rows; scores of
// the previous row live in a memory of MAX_LEN entries whose contents are
// only used from the second row on, so no clearing pass is needed.
// Configuration is to be written only while the block is idle; the block
// itself does not enforce this, and cfg_ready is always high.
module local_alignment_score_fill #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned SCORE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_best_score,
  output logic [10:0] out_end_row,
  output logic [10:0] out_end_column,
  output logic        out_swapped,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  las_pkg::ctrl_t ctrl;
  las_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  las_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  las_dp #(
    .MAX_LEN     (MAX_LEN),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .stat           (stat),
    .in_symbol      (in_symbol),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_score (out_best_score),
    .out_end_row    (out_end_row),
    .out_end_column (out_end_column),
    .out_swapped    (out_swapped),
    .out_overflow   (out_overflow)
  );

endmodule

// ----- sim/local_alignment_score_fill_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_alignment_score_fill_tb: self-checking bench for the alignment scorer
// Loads symbol pairs, starts scoring jobs and checks every result beat against
// a local scoring predictor or a table value; directed table jobs come first,
// then random jobs, random register settings, bursty input and output stalls.
// ----------------------------------------------------------------------------
module local_alignment_score_fill_tb;

  localparam int SEQ_DEPTH   = 1024;
  localparam int SCORE_WIDTH = 16;
  localparam int SCORE_HI    = (1 << (SCORE_WIDTH - 1)) - 1;
  localparam int SCORE_LO    = -(1 << (SCORE_WIDTH - 1));
  localparam int BEST_MAX    = (1 << las_pkg::BEST_WIDTH) - 1;
  localparam int RANDOM_BEATS = 1000;

  // command code the block leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] CFG_REGS [4] = '{las_pkg::REG_MATCH, las_pkg::REG_MISMATCH,
                                          las_pkg::REG_GAP_OPEN,
                                          las_pkg::REG_GAP_EXTEND};

  typedef struct packed {
    logic [las_pkg::BEST_WIDTH-1:0] score;
    logic [las_pkg::POS_WIDTH-1:0]  row;
    logic [las_pkg::POS_WIDTH-1:0]  col;
    logic                           swapped;
    logic                           overflow;
  } align_result_t;

  typedef struct {
    bit            wr_cfg;
    logic [7:0]    m_score;
    logic [7:0]    mm_pen;
    logic [7:0]    go_pen;
    logic [7:0]    ge_pen;
    int            n_first;
    int            n_second;
    logic [7:0]    sym_first;
    logic [7:0]    sym_second;
    bit            mixed;     // draw each symbol from the pair at random
    int            n_noise;   // unused-command beats before the start
    bit            typed;
    align_result_t exp;
  } job_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_RUNS} rx_mode_t;

  localparam align_result_t NO_RESULT = '0;

  job_row_t directed_jobs [14] = '{
    // reset settings, nothing loaded
    '{0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 0, 2, 1, '{15'd0, 11'd0, 11'd0, 1'b0, 1'b0}},
    '{0, 0, 0, 0, 0, 1, 1, 8'h00, 8'h00, 0, 0, 1, '{15'd2, 11'd1, 11'd1, 1'b0, 1'b0}},
    '{0, 0, 0, 0, 0, 1, 3, 8'hFF, 8'hFF, 0, 0, 1, '{15'd2, 11'd1, 11'd3, 1'b1, 1'b0}},
    // nothing matches: no cell reaches zero
    '{0, 0, 0, 0, 0, 4, 4, 8'h00, 8'hFF, 0, 0, 1, '{15'd0, 11'd0, 11'd0, 1'b0, 1'b0}},
    // first sequence overflows, second empty
    '{0, 0, 0, 0, 0, 1025, 0, 8'h5A, 8'h00, 0, 0, 1,
      '{15'd0, 11'd0, 11'd0, 1'b0, 1'b1}},
    // full-width columns from the second sequence, one dropped beat
    '{0, 0, 0, 0, 0, 1, 1025, 8'h33, 8'h33, 0, 0, 1,
      '{15'd2, 11'd1, 11'd1024, 1'b1, 1'b1}},
    // long diagonal run saturates the score
    '{1, 255, 0, 0, 0, 130, 130, 8'hC3, 8'hC3, 0, 0, 0, NO_RESULT},
    '{1, 0, 0, 0, 0, 5, 7, 8'h11, 8'h22, 1, 0, 0, NO_RESULT},
    '{1, 0, 255, 255, 255, 6, 6, 8'hA5, 8'h5A, 1, 0, 0, NO_RESULT},
    '{1, 3, 255, 255, 0, 9, 8, 8'h01, 8'h80, 1, 0, 0, NO_RESULT},
    '{1, 1, 1, 0, 255, 10, 10, 8'h7F, 8'hFE, 1, 1, 0, NO_RESULT},
    '{1, 255, 255, 255, 255, 12, 5, 8'h00, 8'hFF, 1, 0, 0, NO_RESULT},
    // rows empty but second sequence longer
    '{0, 0, 0, 0, 0, 0, 3, 8'h44, 8'h44, 0, 1, 1, '{15'd0, 11'd0, 11'd0, 1'b1, 1'b0}},
    '{1, 2, 1, 2, 1, 16, 11, 8'h3C, 8'hC3, 1, 0, 0, NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = las_pkg::CMD_LOAD_FIRST;
  logic [7:0]  in_symbol = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_best_score;
  logic [10:0] out_end_row;
  logic [10:0] out_end_column;
  logic        out_swapped;
  logic        out_overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = las_pkg::REG_MATCH;
  logic [7:0]  cfg_data = 8'd0;

  local_alignment_score_fill u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_best_score (out_best_score),
    .out_end_row    (out_end_row),
    .out_end_column (out_end_column),
    .out_swapped    (out_swapped),
    .out_overflow   (out_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  pm_first_syms  [SEQ_DEPTH];
  logic [7:0]  pm_second_syms [SEQ_DEPTH];
  int unsigned pm_first_len = 0;
  int unsigned pm_second_len = 0;
  bit          pm_dropped = 1'b0;
  int          pm_match = las_pkg::RST_MATCH;
  int          pm_mismatch = las_pkg::RST_MISMATCH;
  int          pm_gap_open = las_pkg::RST_GAP_OPEN;
  int          pm_gap_extend = las_pkg::RST_GAP_EXTEND;

  align_result_t expected_scores [$];
  align_result_t typed_exp = NO_RESULT;
  bit            use_typed = 1'b0;

  int fail_count = 0;
  int results_seen = 0;
  int jobs_started = 0;
  int item_count = 0;
  int cfg_writes = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_run_left = 0;
  bit       rx_level = 1'b0;

  function automatic int clamp_score(input int v);
    if (v > SCORE_HI) return SCORE_HI;
    if (v < SCORE_LO) return SCORE_LO;
    return v;
  endfunction

  // fills the matrix row by row with one previous-row buffer
  function automatic align_result_t score_alignment();
    int row_buf [SEQ_DEPTH + 1];
    int best, left, diag, up, pen, a, b, c, s;
    int unsigned ncols, nrows, bi, bj;
    bit swp, gap;
    logic [7:0] rs, cs;
    align_result_t r;
    swp   = pm_second_len > pm_first_len;
    ncols = swp ? pm_second_len : pm_first_len;
    nrows = swp ? pm_first_len : pm_second_len;
    foreach (row_buf[k]) row_buf[k] = 0;
    gap  = 1'b0;
    best = 0;
    bi   = 0;
    bj   = 0;
    for (int unsigned i = 1; i <= nrows; i++) begin
      left = 0;
      diag = row_buf[0];
      rs   = swp ? pm_first_syms[i-1] : pm_second_syms[i-1];
      for (int unsigned j = 1; j <= ncols; j++) begin
        up  = row_buf[j];
        pen = gap ? pm_gap_extend : pm_gap_open;
        cs  = swp ? pm_second_syms[j-1] : pm_first_syms[j-1];
        a = (cs == rs) ? clamp_score(diag + pm_match) : clamp_score(diag - pm_mismatch);
        b = clamp_score(up - pen);
        c = clamp_score(left - pen);
        if (a >= b && a >= c) begin
          s   = a;
          gap = 1'b0;
        end else begin
          s   = (b >= c) ? b : c;
          gap = 1'b1;
        end
        diag       = up;
        row_buf[j] = (s > 0) ? s : 0;
        left       = row_buf[j];
        if (s >= best) begin
          best = s;
          bi   = i;
          bj   = j;
        end
      end
    end
    r.score    = (best > BEST_MAX) ? BEST_MAX[las_pkg::BEST_WIDTH-1:0]
                                   : best[las_pkg::BEST_WIDTH-1:0];
    r.row      = bi[las_pkg::POS_WIDTH-1:0];
    r.col      = bj[las_pkg::POS_WIDTH-1:0];
    r.swapped  = swp;
    r.overflow = pm_dropped;
    return r;
  endfunction

  function automatic void apply_beat(input logic [1:0] cmd, input logic [7:0] sym);
    align_result_t r;
    case (cmd)
      las_pkg::CMD_LOAD_FIRST: begin
        if (pm_first_len < SEQ_DEPTH) begin
          pm_first_syms[pm_first_len] = sym;
          pm_first_len++;
        end else begin
          pm_dropped = 1'b1;
        end
      end
      las_pkg::CMD_LOAD_SECOND: begin
        if (pm_second_len < SEQ_DEPTH) begin
          pm_second_syms[pm_second_len] = sym;
          pm_second_len++;
        end else begin
          pm_dropped = 1'b1;
        end
      end
      las_pkg::CMD_START: begin
        r = score_alignment();
        expected_scores.insert(expected_scores.size(), use_typed ? typed_exp : r);
        pm_first_len  = 0;
        pm_second_len = 0;
        pm_dropped    = 1'b0;
        jobs_started++;
      end
      default: ;
    endcase
  endfunction

  // one input beat, preceded by a random gap at the start of each burst
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] sym);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  = 1'b1;
    in_cmd    = cmd;
    in_symbol = sym;
    do @(posedge clk); while (in_stall);
    apply_beat(cmd, sym);
    if (cmd != CMD_UNUSED) item_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      las_pkg::REG_MATCH:    pm_match      = val;
      las_pkg::REG_MISMATCH: pm_mismatch   = val;
      las_pkg::REG_GAP_OPEN: pm_gap_open   = val;
      default:               pm_gap_extend = val;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold input until every pending result is out, then let loads settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_job();
    int nf, ns, sel;
    logic [7:0] alph [4];
    bit full;
    sel = $urandom_range(0, 99);
    nf = (sel < 85) ? $urandom_range(0, 12) : (sel < 97) ? $urandom_range(13, 40)
                                                         : $urandom_range(60, 100);
    sel = $urandom_range(0, 99);
    ns = (sel < 85) ? $urandom_range(0, 12) : (sel < 97) ? $urandom_range(13, 40)
                                                         : $urandom_range(60, 100);
    if ($urandom_range(0, 4) == 0) ns = nf;
    foreach (alph[k]) alph[k] = 8'($urandom);
    full = ($urandom_range(0, 9) < 3);
    while (nf > 0 || ns > 0) begin
      if ($urandom_range(0, 19) == 0) send_beat(CMD_UNUSED, 8'($urandom));
      if (ns == 0 || (nf > 0 && $urandom_range(0, 1) == 1)) begin
        send_beat(las_pkg::CMD_LOAD_FIRST, full ? 8'($urandom) : alph[$urandom_range(0, 3)]);
        nf--;
      end else begin
        send_beat(las_pkg::CMD_LOAD_SECOND, full ? 8'($urandom) : alph[$urandom_range(0, 3)]);
        ns--;
      end
    end
    send_beat(las_pkg::CMD_START, 8'($urandom));
  endtask

  // output stall: open, random, or long runs, with the mode drawn at random
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(50, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:   out_stall <= 1'b0;
      RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (rx_run_left == 0) begin
          rx_level    = ~rx_level;
          rx_run_left = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 5);
        end
        rx_run_left--;
        out_stall <= rx_level;
      end
    endcase
  end

  always @(posedge clk) begin
    align_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_best_score, out_end_row, out_end_column, out_swapped, out_overflow};
      results_seen++;
      if (expected_scores.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected result beat: score %0d row %0d col %0d swp %0b ovf %0b",
                   $time, got.score, got.row, got.col, got.swapped, got.overflow);
      end else begin
        want = expected_scores.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] result mismatch: expected score %0d row %0d col %0d swp %0b ovf %0b",
                     $time, want.score, want.row, want.col, want.swapped, want.overflow);
            $display("[%0t]                  actual   score %0d row %0d col %0d swp %0b ovf %0b",
                     $time, got.score, got.row, got.col, got.swapped, got.overflow);
          end
        end
      end
    end
  end

  initial begin
    int base, directed_jobs_done;
    job_row_t jr;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_jobs[r]) begin
      jr = directed_jobs[r];
      if (jr.wr_cfg) begin
        wait_idle();
        write_reg(las_pkg::REG_MATCH, jr.m_score);
        write_reg(las_pkg::REG_MISMATCH, jr.mm_pen);
        write_reg(las_pkg::REG_GAP_OPEN, jr.go_pen);
        write_reg(las_pkg::REG_GAP_EXTEND, jr.ge_pen);
      end
      for (int k = 0; k < jr.n_first; k++)
        send_beat(las_pkg::CMD_LOAD_FIRST,
                  (jr.mixed && $urandom_range(0, 1) == 1) ? jr.sym_second : jr.sym_first);
      for (int k = 0; k < jr.n_second; k++)
        send_beat(las_pkg::CMD_LOAD_SECOND,
                  (jr.mixed && $urandom_range(0, 1) == 1) ? jr.sym_first : jr.sym_second);
      repeat (jr.n_noise) send_beat(CMD_UNUSED, 8'($urandom));
      use_typed = jr.typed;
      typed_exp = jr.exp;
      send_beat(las_pkg::CMD_START, 8'($urandom));
      use_typed = 1'b0;
    end
    directed_jobs_done = jobs_started;

    base = item_count;
    while (item_count - base < RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 12) begin
        wait_idle();
        foreach (CFG_REGS[k])
          if ($urandom_range(0, 1) == 1)
            case ($urandom_range(0, 3))
              0:       write_reg(CFG_REGS[k], 8'd0);
              1:       write_reg(CFG_REGS[k], 8'd255);
              default: write_reg(CFG_REGS[k], 8'($urandom_range(0, 6)));
            endcase
      end else if ($urandom_range(0, 99) < 10) begin
        wait_idle();
      end
      random_job();
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d scoring jobs (%0d directed) over %0d load/start beats, %0d register writes",
             jobs_started, directed_jobs_done, item_count, cfg_writes);
    $display("Checked %0d result beats, %0d mismatches, %0d still pending",
             results_seen, fail_count, expected_scores.size());
    if (fail_count == 0 && expected_scores.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results pending", expected_scores.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- local_alignment_score_fill.f -----
sv/las_pkg.sv
sv/las_ram.sv
sv/las_ctrl.sv
sv/las_dp.sv
sv/local_alignment_score_fill.sv
sim/local_alignment_score_fill_tb.sv
